/* src/hck_pkg.sv */
package hck_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned RemW      = 16;
  localparam int unsigned DivStages = 4;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;

  localparam logic [PixW-1:0] BaseMinRed   = 8'd126;
  localparam logic [PixW-1:0] BaseMinBlue  = 8'd42;
  localparam logic [PixW-1:0] BaseMinGreen = 8'd210;
  localparam logic [PixW:0]   HueRot       = 9'd126;
  localparam logic [PixW:0]   HueRange     = 9'd252;

  localparam logic            KeyEnableRst = 1'b0;
  localparam logic [PixW-1:0] KeyHueRst    = 8'd84;
  localparam logic [PixW-1:0] KeySatRst    = 8'd255;
  localparam logic [PixW-1:0] KeyValRst    = 8'd255;
  localparam logic [PixW-1:0] TolRst       = 8'd0;

  typedef enum logic [2:0] {
    REG_KEY_ENABLE = 3'd0,
    REG_KEY_HUE    = 3'd1,
    REG_KEY_SAT    = 3'd2,
    REG_KEY_VAL    = 3'd3,
    REG_HUE_TOL    = 3'd4,
    REG_SAT_TOL    = 3'd5,
    REG_VAL_TOL    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [PixW-1:0] b;
    logic [PixW-1:0] g;
    logic [PixW-1:0] r;
  } rgb_t;

  typedef struct packed {
    rgb_t            fg;
    rgb_t            bg;
    logic [PixW-1:0] hi;
    logic [PixW-1:0] span;
    logic [PixW-1:0] num_mag;
    logic            num_neg;
    logic [PixW-1:0] base;
    logic            grey;
  } front_t;

  typedef struct packed {
    rgb_t            fg;
    rgb_t            bg;
    logic [PixW-1:0] hi;
    logic [PixW-1:0] span;
    logic            num_neg;
    logic [PixW-1:0] base;
    logic            grey;
    logic [RemW-1:0] rem_h;
    logic [PixW-1:0] quo_h;
    logic [RemW-1:0] rem_s;
    logic [PixW-1:0] quo_s;
  } div_t;

  typedef struct packed {
    rgb_t            fg;
    rgb_t            bg;
    logic [PixW-1:0] hue;
    logic [PixW-1:0] hue_w;
    logic [PixW-1:0] sat;
    logic [PixW-1:0] val;
  } hsv_t;

  typedef struct packed {
    rgb_t            pix;
    logic            keyed;
    logic [PixW-1:0] hue;
    logic [PixW-1:0] sat;
    logic [PixW-1:0] val;
  } out_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic            qbit;
  } div_res_t;

  function automatic div_res_t div_step(logic [RemW-1:0] rem, logic [RemW-1:0] dvs);
    div_res_t res;
    res.qbit = (rem >= dvs);
    res.rem  = res.qbit ? rem - dvs : rem;
    return res;
  endfunction

  // hue rotated by half a turn on the 0..251 circle
  function automatic logic [PixW-1:0] wrap_hue(logic [PixW-1:0] h);
    logic [PixW:0] sum;
    sum = {1'b0, h} + HueRot;
    if (sum >= HueRange) begin
      sum = sum - HueRange;
    end
    return sum[PixW-1:0];
  endfunction

  function automatic logic within_tol(logic [PixW-1:0] a, logic [PixW-1:0] b,
                                      logic [PixW-1:0] tol);
    logic [PixW-1:0] d;
    d = (a > b) ? a - b : b - a;
    return d <= tol;
  endfunction

endpackage

/* src/hsv_chroma_key_core.sv */
// An accepted beat passes the front, dividend, divider, hsv and output registers.
// One pixel per cycle unless the output stalls; the hue and saturation dividers
// retire two quotient bits per stage over four stages, each holding its own beat.
// Bubbles collapse, so input is taken while an output beat waits if a stage is empty.
// Reset (rst_ni low, async) empties the pipeline and loads register defaults.
module hsv_chroma_key_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_red, out_green, out_blue, pixel_hue, pixel_saturation, pixel_value
  output logic [47:0] m_axis_tdata,
  // keyed
  output logic [0:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [hck_pkg::AddrW-1:0] paddr,
  input  logic [hck_pkg::DataW-1:0] pwdata,
  output logic [hck_pkg::DataW-1:0] prdata,
  output logic        pready
);

  localparam int unsigned PixW = hck_pkg::PixW;
  localparam int unsigned RemW = hck_pkg::RemW;
  localparam int unsigned Nd   = hck_pkg::DivStages;

  // configuration
  logic            key_en_q;
  logic [PixW-1:0] key_hue_q, key_hue_w_q, key_sat_q, key_val_q;
  logic [PixW-1:0] hue_tol_q, sat_tol_q, val_tol_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_en_q    <= hck_pkg::KeyEnableRst;
      key_hue_q   <= hck_pkg::KeyHueRst;
      key_hue_w_q <= hck_pkg::wrap_hue(hck_pkg::KeyHueRst);
      key_sat_q   <= hck_pkg::KeySatRst;
      key_val_q   <= hck_pkg::KeyValRst;
      hue_tol_q   <= hck_pkg::TolRst;
      sat_tol_q   <= hck_pkg::TolRst;
      val_tol_q   <= hck_pkg::TolRst;
    end else if (cfg_wr) begin
      case (hck_pkg::reg_idx_e'(paddr[4:2]))
        hck_pkg::REG_KEY_ENABLE: key_en_q <= pwdata[0];
        hck_pkg::REG_KEY_HUE: begin
          key_hue_q   <= pwdata[PixW-1:0];
          key_hue_w_q <= hck_pkg::wrap_hue(pwdata[PixW-1:0]);
        end
        hck_pkg::REG_KEY_SAT: key_sat_q <= pwdata[PixW-1:0];
        hck_pkg::REG_KEY_VAL: key_val_q <= pwdata[PixW-1:0];
        hck_pkg::REG_HUE_TOL: hue_tol_q <= pwdata[PixW-1:0];
        hck_pkg::REG_SAT_TOL: sat_tol_q <= pwdata[PixW-1:0];
        hck_pkg::REG_VAL_TOL: val_tol_q <= pwdata[PixW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (hck_pkg::reg_idx_e'(paddr[4:2]))
      hck_pkg::REG_KEY_ENABLE: prdata = 32'(key_en_q);
      hck_pkg::REG_KEY_HUE:    prdata = 32'(key_hue_q);
      hck_pkg::REG_KEY_SAT:    prdata = 32'(key_sat_q);
      hck_pkg::REG_KEY_VAL:    prdata = 32'(key_val_q);
      hck_pkg::REG_HUE_TOL:    prdata = 32'(hue_tol_q);
      hck_pkg::REG_SAT_TOL:    prdata = 32'(sat_tol_q);
      hck_pkg::REG_VAL_TOL:    prdata = 32'(val_tol_q);
      default:                 prdata = '0;
    endcase
  end

  // pipeline registers and stage enables
  hck_pkg::front_t front_d, front_q;
  logic            front_v_q;
  hck_pkg::div_t   div_q [Nd+1];
  hck_pkg::div_t   div_d [Nd+1];
  logic            div_v_q [Nd+1];
  hck_pkg::hsv_t   hsv_d, hsv_q;
  logic            hsv_v_q;
  hck_pkg::out_t   out_d, out_q;
  logic            out_v_q;

  logic            en_front, en_hsv, en_out;
  logic            en_div [Nd+1];

  always_comb begin
    en_out     = !out_v_q | m_axis_tready;
    en_hsv     = !hsv_v_q | en_out;
    en_div[Nd] = !div_v_q[Nd] | en_hsv;
    for (int k = Nd - 1; k >= 0; k--) begin
      en_div[k] = !div_v_q[k] | en_div[k+1];
    end
    en_front = !front_v_q | en_div[0];
  end

  assign s_axis_tready = en_front;

  // stage 1: max, min, hue sextant and signed numerator
  always_comb begin
    hck_pkg::rgb_t   fg;
    logic [PixW-1:0] lo, hi, pos, neg;
    fg = '{r: s_axis_tdata[7:0], g: s_axis_tdata[15:8], b: s_axis_tdata[23:16]};
    lo = (fg.r < fg.g) ? fg.r : fg.g;
    hi = (fg.r > fg.g) ? fg.r : fg.g;
    if (fg.b < lo) begin
      lo = fg.b;
    end
    if (fg.b > hi) begin
      hi = fg.b;
    end
    if (fg.r == lo) begin
      pos = fg.g;
      neg = fg.b;
      front_d.base = hck_pkg::BaseMinRed;
    end else if (fg.b == lo) begin
      pos = fg.r;
      neg = fg.g;
      front_d.base = hck_pkg::BaseMinBlue;
    end else begin
      pos = fg.b;
      neg = fg.r;
      front_d.base = hck_pkg::BaseMinGreen;
    end
    front_d.fg      = fg;
    front_d.bg      = '{r: s_axis_tdata[31:24], g: s_axis_tdata[39:32],
                        b: s_axis_tdata[47:40]};
    front_d.hi      = hi;
    front_d.span    = hi - lo;
    front_d.num_neg = pos < neg;
    front_d.num_mag = (pos < neg) ? neg - pos : pos - neg;
    front_d.grey    = (lo == hi);
  end

  // stage 2: dividends |num|*42 and span*255
  always_comb begin
    div_d[0]         = '0;
    div_d[0].fg      = front_q.fg;
    div_d[0].bg      = front_q.bg;
    div_d[0].hi      = front_q.hi;
    div_d[0].span    = front_q.span;
    div_d[0].num_neg = front_q.num_neg;
    div_d[0].base    = front_q.base;
    div_d[0].grey    = front_q.grey;
    div_d[0].rem_h   = {3'b0, front_q.num_mag, 5'b0} + {5'b0, front_q.num_mag, 3'b0}
                     + {7'b0, front_q.num_mag, 1'b0};
    div_d[0].rem_s   = {front_q.span, 8'b0} - {8'b0, front_q.span};
  end

  // stages 3..6: restoring division, two quotient bits per stage
  for (genvar j = 0; j < Nd; j++) begin : g_div
    localparam int unsigned ShA = 2 * (Nd - j) - 1;
    logic [RemW-1:0]   dvs_h, dvs_s;
    hck_pkg::div_res_t h1, h2, s1, s2;

    always_comb begin
      dvs_h = {8'b0, div_q[j].span} << ShA;
      dvs_s = {8'b0, div_q[j].hi} << ShA;
      h1 = hck_pkg::div_step(div_q[j].rem_h, dvs_h);
      h2 = hck_pkg::div_step(h1.rem, dvs_h >> 1);
      s1 = hck_pkg::div_step(div_q[j].rem_s, dvs_s);
      s2 = hck_pkg::div_step(s1.rem, dvs_s >> 1);
      div_d[j+1]       = div_q[j];
      div_d[j+1].rem_h = h2.rem;
      div_d[j+1].quo_h = {div_q[j].quo_h[PixW-3:0], h1.qbit, h2.qbit};
      div_d[j+1].rem_s = s2.rem;
      div_d[j+1].quo_s = {div_q[j].quo_s[PixW-3:0], s1.qbit, s2.qbit};
    end

    always_ff @(posedge clk_i) begin
      if (en_div[j+1]) begin
        div_q[j+1] <= div_d[j+1];
      end
    end
  end

  // stage 7: hue, saturation, value and rotated hue
  always_comb begin
    hck_pkg::div_t d;
    logic [PixW-1:0] hue;
    d = div_q[Nd];
    if (d.grey) begin
      hue = '0;
    end else if (d.num_neg) begin
      hue = d.base + d.quo_h;
    end else begin
      hue = d.base - d.quo_h;
    end
    hsv_d.fg    = d.fg;
    hsv_d.bg    = d.bg;
    hsv_d.hue   = hue;
    hsv_d.hue_w = hck_pkg::wrap_hue(hue);
    hsv_d.sat   = d.grey ? '0 : d.quo_s;
    hsv_d.val   = d.hi;
  end

  // stage 8: key match and pixel select
  always_comb begin
    logic hue_ok, hit;
    hue_ok = hck_pkg::within_tol(hsv_q.hue, key_hue_q, hue_tol_q) ||
             hck_pkg::within_tol(hsv_q.hue_w, key_hue_w_q, hue_tol_q);
    hit = key_en_q && hue_ok &&
          hck_pkg::within_tol(hsv_q.sat, key_sat_q, sat_tol_q) &&
          hck_pkg::within_tol(hsv_q.val, key_val_q, val_tol_q);
    out_d.pix   = hit ? hsv_q.bg : hsv_q.fg;
    out_d.keyed = hit;
    out_d.hue   = hsv_q.hue;
    out_d.sat   = hsv_q.sat;
    out_d.val   = hsv_q.val;
  end

  always_ff @(posedge clk_i) begin
    if (en_front) begin
      front_q <= front_d;
    end
    if (en_div[0]) begin
      div_q[0] <= div_d[0];
    end
    if (en_hsv) begin
      hsv_q <= hsv_d;
    end
    if (en_out) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= 1'b0;
      for (int k = 0; k <= Nd; k++) begin
        div_v_q[k] <= 1'b0;
      end
      hsv_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_front) begin
        front_v_q <= s_axis_tvalid;
      end
      if (en_div[0]) begin
        div_v_q[0] <= front_v_q;
      end
      for (int k = 0; k < Nd; k++) begin
        if (en_div[k+1]) begin
          div_v_q[k+1] <= div_v_q[k];
        end
      end
      if (en_hsv) begin
        hsv_v_q <= div_v_q[Nd];
      end
      if (en_out) begin
        out_v_q <= hsv_v_q;
      end
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.val, out_q.sat, out_q.hue,
                          out_q.pix.b, out_q.pix.g, out_q.pix.r};
  assign m_axis_tuser  = out_q.keyed;

  ap_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register is empty");

  ap_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_q.sat == '0) |-> (out_q.hue == '0))
    else $error("zero saturation with nonzero hue");

  ap_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, out_q.hue} <= hck_pkg::HueRange))
    else $error("hue out of range");

  ap_keyed_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_q.keyed |-> key_en_q)
    else $error("pixel keyed while keying disabled");

endmodule
